// File: design/dpp_pkg.sv
// Shared types, register codes and reset values for the depth pixel to point core.
`default_nettype none

package dpp_pkg;

    localparam int unsigned MAX_IMAGE_WIDTH  = 4096;
    localparam int unsigned MAX_IMAGE_HEIGHT = 4096;

    localparam int ROW_W   = 12;
    localparam int COL_W   = 12;
    localparam int DEPTH_W = 16;
    localparam int COLOR_W = 8;
    localparam int Z_W     = 24;
    localparam int COORD_W = 32;
    localparam int SCALE_W = 32;
    localparam int CTR_W   = 16;
    localparam int INVF_W  = 24;
    localparam int OFS_W   = 16;
    localparam int T_W     = Z_W + INVF_W;
    localparam int FRAC_SHIFT = 28;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y = 3'd4;

    localparam logic [SCALE_W-1:0] RST_DEPTH_SCALE = 32'd536814;
    localparam logic [CTR_W-1:0]   RST_CENTER_X    = 16'd5005;
    localparam logic [CTR_W-1:0]   RST_CENTER_Y    = 16'd3866;
    localparam logic [INVF_W-1:0]  RST_INV_FOCAL_X = 24'd26970;
    localparam logic [INVF_W-1:0]  RST_INV_FOCAL_Y = 24'd26970;

    typedef struct packed {
        logic [SCALE_W-1:0] depth_scale;
        logic [CTR_W-1:0]   center_x;
        logic [CTR_W-1:0]   center_y;
        logic [INVF_W-1:0]  inv_focal_x;
        logic [INVF_W-1:0]  inv_focal_y;
    } cfg_t;

    // Load enables for the stages inside the lateral units.
    typedef struct packed {
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } lat_ld_t;

endpackage

`default_nettype wire

// File: design/dpp_cfg_regs.sv
// Configuration register file for the depth pixel to point core.
`default_nettype none

module dpp_cfg_regs (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [dpp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dpp_pkg::CFG_DATA_W-1:0]    cfg_data,
    output      dpp_pkg::cfg_t                     cfg
);

    dpp_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.depth_scale <= dpp_pkg::RST_DEPTH_SCALE;
            cfg_reg.center_x    <= dpp_pkg::RST_CENTER_X;
            cfg_reg.center_y    <= dpp_pkg::RST_CENTER_Y;
            cfg_reg.inv_focal_x <= dpp_pkg::RST_INV_FOCAL_X;
            cfg_reg.inv_focal_y <= dpp_pkg::RST_INV_FOCAL_Y;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dpp_pkg::CFG_DEPTH_SCALE: begin
                    cfg_reg.depth_scale <= cfg_data;
                end
                dpp_pkg::CFG_CENTER_X: begin
                    cfg_reg.center_x <= cfg_data[dpp_pkg::CTR_W-1:0];
                end
                dpp_pkg::CFG_CENTER_Y: begin
                    cfg_reg.center_y <= cfg_data[dpp_pkg::CTR_W-1:0];
                end
                dpp_pkg::CFG_INV_FOCAL_X: begin
                    cfg_reg.inv_focal_x <= cfg_data[dpp_pkg::INVF_W-1:0];
                end
                dpp_pkg::CFG_INV_FOCAL_Y: begin
                    cfg_reg.inv_focal_y <= cfg_data[dpp_pkg::INVF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/dpp_lateral.sv
// Lateral coordinate pipeline: |offset| * z * inv_focal >> 28, signed and saturated.
`default_nettype none

module dpp_lateral (
    input  wire logic                              aclk,
    input  wire dpp_pkg::lat_ld_t                  ld,
    input  wire logic [dpp_pkg::Z_W-1:0]           z_in,
    input  wire logic [dpp_pkg::INVF_W-1:0]        inv_focal,
    input  wire logic [dpp_pkg::OFS_W-1:0]         offset_in,
    input  wire logic                              neg_in,
    output      logic signed [dpp_pkg::COORD_W-1:0] coord,
    output      logic                              clip
);

    localparam int HALF_W = dpp_pkg::T_W / 2;
    localparam int PP_W   = dpp_pkg::OFS_W + HALF_W;
    localparam int PROD_W = dpp_pkg::OFS_W + dpp_pkg::T_W;
    localparam int MAG_W  = PROD_W - dpp_pkg::FRAC_SHIFT;

    logic [dpp_pkg::T_W-1:0]   t_reg;
    logic [dpp_pkg::OFS_W-1:0] ofs3_reg;
    logic                      neg3_reg, neg4_reg, neg5_reg;
    logic [PP_W-1:0]           plo_reg, phi_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic signed [dpp_pkg::COORD_W-1:0] coord_reg, coord_next;
    logic                      clip_reg, clip_next;
    logic [MAG_W-1:0]          mag;

    assign mag = prod_reg[PROD_W-1:dpp_pkg::FRAC_SHIFT];

    always_comb begin
        if (!neg5_reg) begin
            clip_next  = |mag[MAG_W-1:dpp_pkg::COORD_W-1];
            coord_next = clip_next ? {1'b0, {(dpp_pkg::COORD_W-1){1'b1}}}
                                   : mag[dpp_pkg::COORD_W-1:0];
        end else begin
            // The most negative value is reachable exactly, one above its magnitude clips.
            clip_next = (|mag[MAG_W-1:dpp_pkg::COORD_W]) ||
                        (mag[dpp_pkg::COORD_W-1] && (|mag[dpp_pkg::COORD_W-2:0]));
            coord_next = clip_next ? {1'b1, {(dpp_pkg::COORD_W-1){1'b0}}}
                                   : -mag[dpp_pkg::COORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld.s3) begin
            t_reg    <= z_in * inv_focal;
            ofs3_reg <= offset_in;
            neg3_reg <= neg_in;
        end
        if (ld.s4) begin
            plo_reg  <= ofs3_reg * t_reg[HALF_W-1:0];
            phi_reg  <= ofs3_reg * t_reg[dpp_pkg::T_W-1:HALF_W];
            neg4_reg <= neg3_reg;
        end
        if (ld.s5) begin
            prod_reg <= {phi_reg, {HALF_W{1'b0}}} + PROD_W'(plo_reg);
            neg5_reg <= neg4_reg;
        end
        if (ld.s6) begin
            coord_reg <= coord_next;
            clip_reg  <= clip_next;
        end
    end

    assign coord = coord_reg;
    assign clip  = clip_reg;

endmodule

`default_nettype wire

// File: design/depth_pixel_to_point_core.sv
// Top level: depth pixel to colored 3D point, six-stage pipeline.
//
//  Channel  Ports      Direction  Carries
//  s_       valid/ready  in       one pixel request: row, column, depth, color bytes
//  m_       valid/ready  out      one colored point per pixel with nonzero depth
//  cfg_     valid/ready  in       register index and write data
//
// An accepted request passes stage registers 1 to 6 to reach m_valid; one request
// can enter every cycle unless stalled. Stage 1 forms depth times scale and the
// pixel offsets, stage 2 saturates z, stages 3 to 5 form offset * z * inv_focal
// in 16x24 pieces, stage 6 saturates and signs x and y. Reset clears the stage
// valid bits and loads the register defaults. A stall holds the run of full stages
// at the output; stages behind it still fill, so input is taken if any stage is empty.
`default_nettype none

module depth_pixel_to_point_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               s_valid,
    output      logic                               s_ready,
    input  wire logic [dpp_pkg::ROW_W-1:0]          s_pixel_row,
    input  wire logic [dpp_pkg::COL_W-1:0]          s_pixel_col,
    input  wire logic [dpp_pkg::DEPTH_W-1:0]        s_raw_depth,
    input  wire logic [dpp_pkg::COLOR_W-1:0]        s_blue,
    input  wire logic [dpp_pkg::COLOR_W-1:0]        s_green,
    input  wire logic [dpp_pkg::COLOR_W-1:0]        s_red,

    output      logic                               m_valid,
    input  wire logic                               m_ready,
    output      logic signed [dpp_pkg::COORD_W-1:0] m_point_x,
    output      logic signed [dpp_pkg::COORD_W-1:0] m_point_y,
    output      logic [dpp_pkg::Z_W-1:0]            m_point_z,
    output      logic [dpp_pkg::COLOR_W-1:0]        m_out_blue,
    output      logic [dpp_pkg::COLOR_W-1:0]        m_out_green,
    output      logic [dpp_pkg::COLOR_W-1:0]        m_out_red,
    output      logic                               m_clipped,

    input  wire logic                               cfg_valid,
    output      logic                               cfg_ready,
    input  wire logic [dpp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dpp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int STAGES  = 6;
    localparam int ZPROD_W = dpp_pkg::DEPTH_W + dpp_pkg::SCALE_W;
    localparam int RGB_W   = 3 * dpp_pkg::COLOR_W;

    dpp_pkg::cfg_t   cfg;
    dpp_pkg::lat_ld_t lat_ld;

    logic [STAGES:1]   valid_reg;
    logic [STAGES+1:1] rdy;
    logic [STAGES:1]   ld;
    logic              accept, keep;

    logic [ZPROD_W-1:0]        zprod_reg;
    logic [dpp_pkg::Z_W-1:0]   z_reg [2:STAGES];
    logic [RGB_W-1:0]          rgb_reg [1:STAGES];
    logic [dpp_pkg::OFS_W-1:0] ofsx1_reg, ofsy1_reg, ofsx2_reg, ofsy2_reg;
    logic                      negx1_reg, negy1_reg, negx2_reg, negy2_reg;
    logic [dpp_pkg::OFS_W-1:0] p16x, p16y, ofsx_next, ofsy_next;
    logic                      negx_next, negy_next;
    logic [dpp_pkg::SCALE_W-1:0] zfull;
    logic [dpp_pkg::Z_W-1:0]   z_next;
    logic                      clipx, clipy;

    dpp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Each stage takes a new request when it is empty or its successor moves.
    always_comb begin
        rdy[STAGES+1] = m_ready;
        for (int k = STAGES; k >= 1; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign s_ready = rdy[1];
    assign accept  = s_valid && s_ready;
    assign keep    = (s_raw_depth != '0) &&
                     (32'(s_pixel_row) < dpp_pkg::MAX_IMAGE_HEIGHT) &&
                     (32'(s_pixel_col) < dpp_pkg::MAX_IMAGE_WIDTH);

    always_comb begin
        ld[1] = rdy[1] && accept && keep;
        for (int k = 2; k <= STAGES; k++) begin
            ld[k] = rdy[k] && valid_reg[k-1];
        end
    end

    assign lat_ld.s3 = ld[3];
    assign lat_ld.s4 = ld[4];
    assign lat_ld.s5 = ld[5];
    assign lat_ld.s6 = ld[6];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[1]) begin
                valid_reg[1] <= accept && keep;
            end
            for (int k = 2; k <= STAGES; k++) begin
                if (rdy[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Offsets in 1/16 pixel, kept as magnitude and sign.
    always_comb begin
        p16x      = {s_pixel_col, 4'b0000};
        p16y      = {s_pixel_row, 4'b0000};
        negx_next = p16x < cfg.center_x;
        negy_next = p16y < cfg.center_y;
        ofsx_next = negx_next ? (cfg.center_x - p16x) : (p16x - cfg.center_x);
        ofsy_next = negy_next ? (cfg.center_y - p16y) : (p16y - cfg.center_y);
    end

    assign zfull  = zprod_reg[ZPROD_W-1:16];
    assign z_next = (|zfull[dpp_pkg::SCALE_W-1:dpp_pkg::Z_W]) ? '1
                                                              : zfull[dpp_pkg::Z_W-1:0];

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            zprod_reg  <= s_raw_depth * cfg.depth_scale;
            ofsx1_reg  <= ofsx_next;
            ofsy1_reg  <= ofsy_next;
            negx1_reg  <= negx_next;
            negy1_reg  <= negy_next;
            rgb_reg[1] <= {s_blue, s_green, s_red};
        end
        if (ld[2]) begin
            z_reg[2]   <= z_next;
            ofsx2_reg  <= ofsx1_reg;
            ofsy2_reg  <= ofsy1_reg;
            negx2_reg  <= negx1_reg;
            negy2_reg  <= negy1_reg;
            rgb_reg[2] <= rgb_reg[1];
        end
        for (int k = 3; k <= STAGES; k++) begin
            if (ld[k]) begin
                z_reg[k]   <= z_reg[k-1];
                rgb_reg[k] <= rgb_reg[k-1];
            end
        end
    end

    dpp_lateral u_lat_x (
        .aclk      (aclk),
        .ld        (lat_ld),
        .z_in      (z_reg[2]),
        .inv_focal (cfg.inv_focal_x),
        .offset_in (ofsx2_reg),
        .neg_in    (negx2_reg),
        .coord     (m_point_x),
        .clip      (clipx)
    );

    dpp_lateral u_lat_y (
        .aclk      (aclk),
        .ld        (lat_ld),
        .z_in      (z_reg[2]),
        .inv_focal (cfg.inv_focal_y),
        .offset_in (ofsy2_reg),
        .neg_in    (negy2_reg),
        .coord     (m_point_y),
        .clip      (clipy)
    );

    assign m_valid     = valid_reg[STAGES];
    assign m_point_z   = z_reg[STAGES];
    assign m_out_blue  = rgb_reg[STAGES][RGB_W-1:2*dpp_pkg::COLOR_W];
    assign m_out_green = rgb_reg[STAGES][2*dpp_pkg::COLOR_W-1:dpp_pkg::COLOR_W];
    assign m_out_red   = rgb_reg[STAGES][dpp_pkg::COLOR_W-1:0];
    assign m_clipped   = clipx || clipy;

    a_zero_depth_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_raw_depth == '0) |=> !valid_reg[1])
        else $error("zero depth request entered the pipeline");

    a_depth_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_raw_depth != '0) |=> valid_reg[1])
        else $error("request with depth was lost at stage 1");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&valid_reg))
        else $error("input stalled while a stage was empty");

    a_zero_z_zero_xy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_point_z == '0) |-> (m_point_x == '0 && m_point_y == '0 && !m_clipped))
        else $error("nonzero lateral coordinate at zero depth");

endmodule

`default_nettype wire
